@@ hdl/cba_pkg.sv @@
// shared operation and status codes, block count and controller state type for the block allocator
package cba_pkg;

    localparam int NUM_BLOCKS = 128;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_EXTEND = 2'd1;
    localparam logic [1:0] OP_FREE   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ALLOC = 7'b0000010,
        S_WALK  = 7'b0000100,
        S_POP   = 7'b0001000,
        S_LINK  = 7'b0010000,
        S_FREE  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

endpackage

@@ hdl/cba_link_mem.sv @@
// next-link memory with a clearing pass after reset that sets every link to the end marker
module cba_link_mem #(
    parameter int NUM_BLOCKS = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [$clog2(NUM_BLOCKS)-1:0] i_waddr,
    input  logic [$clog2(NUM_BLOCKS):0]   i_wdata,
    input  logic [$clog2(NUM_BLOCKS)-1:0] i_raddr,
    output logic [$clog2(NUM_BLOCKS):0]   o_rdata,
    output logic                          o_busy
);

    localparam int BW = $clog2(NUM_BLOCKS);
    localparam int LW = BW + 1;
    localparam logic [LW-1:0] LINK_END = {LW{1'b1}};

    logic [LW-1:0] mem [NUM_BLOCKS];
    logic [LW-1:0] r_rdata;
    logic          r_busy;
    logic          n_busy;
    logic [BW-1:0] r_clr_idx;
    logic [BW-1:0] n_clr_idx;
    logic          w_en;
    logic [BW-1:0] w_addr;
    logic [LW-1:0] w_data;

    always_comb begin
        n_busy    = r_busy;
        n_clr_idx = r_clr_idx;
        if (r_busy) begin
            n_clr_idx = r_clr_idx + BW'(1);
            if (r_clr_idx == BW'(NUM_BLOCKS - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    assign w_en   = r_busy | i_we;
    assign w_addr = r_busy ? r_clr_idx : i_waddr;
    assign w_data = r_busy ? LINK_END : i_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else begin
            r_busy    <= n_busy;
            r_clr_idx <= n_clr_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

@@ hdl/cba_stack_mem.sv @@
// free-block stack memory; entries below the low-water mark were never written and read as their index
module cba_stack_mem #(
    parameter int NUM_BLOCKS = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [$clog2(NUM_BLOCKS)-1:0] i_waddr,
    input  logic [$clog2(NUM_BLOCKS)-1:0] i_wdata,
    input  logic [$clog2(NUM_BLOCKS)-1:0] i_raddr,
    input  logic                          i_take,
    output logic [$clog2(NUM_BLOCKS)-1:0] o_rdata
);

    localparam int BW = $clog2(NUM_BLOCKS);
    localparam int CW = $clog2(NUM_BLOCKS + 1);

    logic [BW-1:0] mem [NUM_BLOCKS];
    logic [BW-1:0] r_rdata;
    logic [BW-1:0] r_raddr;
    logic          r_fresh;
    logic [CW-1:0] r_low;
    logic [CW-1:0] n_low;

    always_comb begin
        n_low = r_low;
        if (i_take && (CW'(r_raddr) < r_low)) begin
            n_low = CW'(r_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low <= CW'(NUM_BLOCKS);
        end else begin
            r_low <= n_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
        r_raddr <= i_raddr;
        r_fresh <= CW'(i_raddr) < r_low;
    end

    assign o_rdata = r_fresh ? r_raddr : r_rdata;

endmodule

@@ hdl/chained_block_allocator.sv @@
// chained block allocator top level: request decode, chain walk sequencer and result register
// A request is accepted in S_IDLE, steps through one state per memory access and posts its
// result from S_DONE. Allocate runs S_ALLOC; extend walks the chain in S_WALK, then runs S_POP
// and S_LINK; free walks the chain in S_WALK, then pushes each block back in S_FREE. The link
// memory's single read port serves one link per cycle during the walk and the push-back. An
// unused op or an out of range block goes straight to S_DONE, an allocate on an empty stack
// via S_ALLOC, and a request rejected while reading its chain from S_WALK. After reset the link
// memory runs a clearing pass over every link, stalling requests. A finished result sits in an
// output register until taken; while an earlier result still waits there the sequencer holds in S_DONE.
module chained_block_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_op,
    input  logic [6:0] i_block,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic [6:0] o_new_block,
    output logic [7:0] o_blocks_freed,
    output logic [7:0] o_in_use
);

    localparam int NUM_BLOCKS = cba_pkg::NUM_BLOCKS;
    localparam int BW = $clog2(NUM_BLOCKS);
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int LW = BW + 1;
    localparam int XW = (CW > 7) ? CW : 7;
    localparam logic [LW-1:0] LINK_END = {LW{1'b1}};

    cba_pkg::t_state r_state, n_state;
    logic [1:0]      r_op, n_op;
    logic [BW-1:0]   r_start, n_start;
    logic [BW-1:0]   r_cur, n_cur;
    logic [CW-1:0]   r_n, n_n;
    logic [CW-1:0]   r_free, n_free;
    logic [CW-1:0]   r_used, n_used;
    logic [CW-1:0]   r_freed, n_freed;
    logic [BW-1:0]   r_newb, n_newb;
    logic [1:0]      r_status, n_status;
    logic            r_out_valid, n_out_valid;
    logic [1:0]      r_out_status, n_out_status;
    logic [6:0]      r_out_newb, n_out_newb;
    logic [7:0]      r_out_freed, n_out_freed;
    logic [7:0]      r_out_used, n_out_used;

    logic            lk_we;
    logic [BW-1:0]   lk_waddr;
    logic [LW-1:0]   lk_wdata;
    logic [BW-1:0]   lk_raddr;
    logic [LW-1:0]   lk_rdata;
    logic            lk_busy;
    logic            st_we;
    logic [BW-1:0]   st_waddr;
    logic [BW-1:0]   st_wdata;
    logic [BW-1:0]   st_raddr;
    logic            st_take;
    logic [BW-1:0]   st_rdata;

    logic            slot_free;
    logic            link_end;
    logic            link_bad;
    logic            overflow;

    cba_link_mem #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) u_link_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata),
        .o_busy  (lk_busy)
    );

    cba_stack_mem #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) u_stack_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .i_take  (st_take),
        .o_rdata (st_rdata)
    );

    assign slot_free = !r_out_valid || !i_out_stall;
    assign link_end  = lk_rdata == LINK_END;
    assign link_bad  = (lk_rdata >= LW'(NUM_BLOCKS)) || (r_n >= CW'(NUM_BLOCKS));
    assign overflow  = ({1'b0, r_free} + {1'b0, r_n}) > (CW + 1)'(NUM_BLOCKS);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_start      = r_start;
        n_cur        = r_cur;
        n_n          = r_n;
        n_free       = r_free;
        n_used       = r_used;
        n_freed      = r_freed;
        n_newb       = r_newb;
        n_status     = r_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_newb   = r_out_newb;
        n_out_freed  = r_out_freed;
        n_out_used   = r_out_used;
        lk_we        = 1'b0;
        lk_waddr     = r_cur;
        lk_wdata     = LINK_END;
        lk_raddr     = r_cur;
        st_we        = 1'b0;
        st_waddr     = r_free[BW-1:0];
        st_wdata     = r_cur;
        st_raddr     = BW'(r_free - CW'(1));
        st_take      = 1'b0;

        unique case (r_state)
            cba_pkg::S_IDLE: begin
                lk_raddr = BW'(i_block);
                if (i_in_valid && !lk_busy) begin
                    n_op     = i_op;
                    n_start  = BW'(i_block);
                    n_cur    = BW'(i_block);
                    n_n      = CW'(1);
                    n_newb   = '0;
                    n_freed  = '0;
                    n_status = cba_pkg::ST_OK;
                    case (i_op) inside
                        cba_pkg::OP_ALLOC: begin
                            n_state = cba_pkg::S_ALLOC;
                        end
                        cba_pkg::OP_EXTEND, cba_pkg::OP_FREE: begin
                            if (XW'(i_block) >= XW'(NUM_BLOCKS)) begin
                                n_status = cba_pkg::ST_BAD;
                                n_state  = cba_pkg::S_DONE;
                            end else begin
                                n_state = cba_pkg::S_WALK;
                            end
                        end
                        default: begin
                            n_state = cba_pkg::S_DONE;
                        end
                    endcase
                end
            end
            cba_pkg::S_ALLOC: begin
                if (r_free == '0) begin
                    n_status = cba_pkg::ST_NOSPACE;
                end else begin
                    lk_we    = 1'b1;
                    lk_waddr = st_rdata;
                    st_take  = 1'b1;
                    n_free   = r_free - CW'(1);
                    n_used   = r_used + CW'(1);
                    n_newb   = st_rdata;
                end
                n_state = cba_pkg::S_DONE;
            end
            cba_pkg::S_WALK: begin
                if (link_end) begin
                    if (r_op == cba_pkg::OP_EXTEND) begin
                        if (r_free == '0) begin
                            n_status = cba_pkg::ST_NOSPACE;
                            n_state  = cba_pkg::S_DONE;
                        end else begin
                            n_state = cba_pkg::S_POP;
                        end
                    end else if (overflow) begin
                        n_status = cba_pkg::ST_BAD;
                        n_state  = cba_pkg::S_DONE;
                    end else begin
                        lk_raddr = r_start;
                        n_cur    = r_start;
                        n_state  = cba_pkg::S_FREE;
                    end
                end else if (link_bad) begin
                    n_status = cba_pkg::ST_BAD;
                    n_state  = cba_pkg::S_DONE;
                end else begin
                    lk_raddr = lk_rdata[BW-1:0];
                    n_cur    = lk_rdata[BW-1:0];
                    n_n      = r_n + CW'(1);
                end
            end
            cba_pkg::S_POP: begin
                lk_we    = 1'b1;
                lk_waddr = st_rdata;
                st_take  = 1'b1;
                n_free   = r_free - CW'(1);
                n_used   = r_used + CW'(1);
                n_newb   = st_rdata;
                n_state  = cba_pkg::S_LINK;
            end
            cba_pkg::S_LINK: begin
                lk_we    = 1'b1;
                lk_waddr = r_cur;
                lk_wdata = {1'b0, r_newb};
                n_state  = cba_pkg::S_DONE;
            end
            cba_pkg::S_FREE: begin
                lk_we   = 1'b1;
                st_we   = 1'b1;
                n_free  = r_free + CW'(1);
                n_freed = r_freed + CW'(1);
                if (r_used != '0) begin
                    n_used = r_used - CW'(1);
                end
                if (link_end) begin
                    n_state = cba_pkg::S_DONE;
                end else begin
                    lk_raddr = lk_rdata[BW-1:0];
                    n_cur    = lk_rdata[BW-1:0];
                end
            end
            cba_pkg::S_DONE: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_newb   = 7'(r_newb);
                    n_out_freed  = 8'(r_freed);
                    n_out_used   = 8'(r_used);
                    n_state      = cba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cba_pkg::S_IDLE;
            r_free      <= CW'(NUM_BLOCKS);
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_start      <= n_start;
        r_cur        <= n_cur;
        r_n          <= n_n;
        r_freed      <= n_freed;
        r_newb       <= n_newb;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_newb   <= n_out_newb;
        r_out_freed  <= n_out_freed;
        r_out_used   <= n_out_used;
    end

    assign o_in_stall     = (r_state != cba_pkg::S_IDLE) || lk_busy;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_new_block    = r_out_newb;
    assign o_blocks_freed = r_out_freed;
    assign o_in_use       = r_out_used;

endmodule
